// File: src/fdh_pkg.sv
// ----------------------------------------------------------------------------
// fdh_pkg: shared constants and control word types
// Sizes of the fractional delay line, datapath widths and the microcode word
// that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package fdh_pkg;

  localparam int STORE_DEPTH = 32768;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 24;

  // fixed field widths on the stream ports
  localparam int IN_SAMPLE_W  = 24;
  localparam int DELAY_W      = 23;
  localparam int OUT_W        = 24;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 24;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int POS_W   = ADDR_W + FRAC_BITS;
  localparam int CMP_W   = ((DELAY_W > POS_W) ? DELAY_W : POS_W) + 1;
  localparam int WORK_W  = SAMPLE_BITS + 8;
  localparam int PROD_W  = WORK_W + FRAC_BITS + 1;

  localparam logic [CMP_W-1:0] DELAY_MIN = CMP_W'(longint'(2) << FRAC_BITS);
  localparam logic [CMP_W-1:0] DELAY_MAX =
    CMP_W'(longint'(STORE_DEPTH - 3) << FRAC_BITS);
  localparam logic [CMP_W-1:0] SPAN = CMP_W'(longint'(STORE_DEPTH) << FRAC_BITS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(14);

  // which neighbour of the read index goes to the store's read port
  typedef enum logic [1:0] {
    NB_M1 = 2'd0,
    NB_P0 = 2'd1,
    NB_P1 = 2'd2,
    NB_P2 = 2'd3
  } nb_sel_t;

  // which tap register takes the read data
  typedef enum logic [2:0] {
    LD_NONE = 3'd0,
    LD_XM1  = 3'd1,
    LD_X0   = 3'd2,
    LD_X1   = 3'd3,
    LD_X2   = 3'd4
  } ld_sel_t;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_ADDR = 4'd1,
    OP_DIFF = 4'd2,
    OP_AB   = 4'd3,
    OP_MUL  = 4'd4,
    OP_S1   = 4'd5,
    OP_S2   = 4'd6,
    OP_S3   = 4'd7,
    OP_OUT  = 4'd8
  } op_t;

  // next-step condition
  typedef enum logic [1:0] {
    JC_NEXT = 2'd0,
    JC_IN   = 2'd1,
    JC_OUT  = 2'd2
  } jc_t;

  typedef struct packed {
    logic    rd_en;
    nb_sel_t nb;
    ld_sel_t ld;
    op_t     op;
    jc_t     jc;
  } uword_t;

  function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] a);
    next_idx = (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
  endfunction

endpackage

// File: src/fractional_delay_hermite_top.sv
// ----------------------------------------------------------------------------
// fractional_delay_hermite_top: fractional delay line, 4-point Hermite
// Writes each sample into a circular store, reads four neighbours at the
// delayed position and interpolates them with a cubic Hermite polynomial.
//
//   channel | ports                      | payload, low bit up
//   --------+----------------------------+------------------------------------
//   input   | in_tvalid/tready/tdata     | sample_in[23:0], delay_amount[46:24]
//   result  | out_tvalid/tready/tdata    | sample_out[23:0]
//
// Each item runs a 15-step program, set by the four reads through the store's
// single read port and three passes through the one multiplier; a new request
// is taken only once the program for the previous one has finished.
// Reset clears the write pointer and a fill flag; unwritten entries read zero,
// so no clearing pass is run and the block is ready right after reset.
// A result waits in the output register while the next request is processed;
// the last step holds only if that register is still occupied.
// ----------------------------------------------------------------------------
module fractional_delay_hermite_top import fdh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_in[23:0], delay_amount[46:24]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // sample_out[23:0]
);

  uword_t ctl;
  logic   out_busy;
  logic   in_accept;

  assign in_accept = in_tvalid && in_tready;

  fdh_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_busy  (out_busy),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  fdh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_accept  (in_accept),
    .in_sample  (in_tdata[IN_SAMPLE_W-1:0]),
    .in_delay   (in_tdata[IN_SAMPLE_W+DELAY_W-1:IN_SAMPLE_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_sample (out_tdata),
    .out_busy   (out_busy)
  );

endmodule

// File: src/fdh_ram.sv
// ----------------------------------------------------------------------------
// fdh_ram: simple dual-port sample store
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module fdh_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/fdh_seq.sv
// ----------------------------------------------------------------------------
// fdh_seq: microcode sequencer
// Step counter over a read-only program; each step emits one control word.
// ----------------------------------------------------------------------------
module fdh_seq import fdh_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  input  logic   out_busy,
  output logic   in_tready,
  output uword_t ctl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            uw;

  // program: accept, address, four reads, polynomial, output
  always_comb begin
    uw = '{rd_en: 1'b0, nb: NB_M1, ld: LD_NONE, op: OP_NONE, jc: JC_NEXT};
    case (step_r)
      4'd0:  uw.jc = JC_IN;
      4'd1:  uw.op = OP_ADDR;
      4'd2:  begin uw.rd_en = 1'b1; uw.nb = NB_M1; end
      4'd3:  begin uw.rd_en = 1'b1; uw.nb = NB_P0; uw.ld = LD_XM1; end
      4'd4:  begin uw.rd_en = 1'b1; uw.nb = NB_P1; uw.ld = LD_X0; end
      4'd5:  begin uw.rd_en = 1'b1; uw.nb = NB_P2; uw.ld = LD_X1; end
      4'd6:  begin uw.ld = LD_X2; uw.op = OP_DIFF; end
      4'd7:  uw.op = OP_AB;
      4'd8:  uw.op = OP_MUL;
      4'd9:  uw.op = OP_S1;
      4'd10: uw.op = OP_MUL;
      4'd11: uw.op = OP_S2;
      4'd12: uw.op = OP_MUL;
      4'd13: uw.op = OP_S3;
      4'd14: begin uw.op = OP_OUT; uw.jc = JC_OUT; end
      default: uw.jc = JC_OUT;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    case (uw.jc)
      JC_NEXT: step_nxt = step_r + STEP_W'(1);
      JC_IN:   if (in_tvalid) begin step_nxt = step_r + STEP_W'(1); end
      JC_OUT:  if (!out_busy) begin step_nxt = '0; end
      default: step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_tready = (uw.jc == JC_IN);
  assign ctl       = uw;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> step_r == STEP_W'(1))
    else $error("accepted request did not start the program");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP)
    else $error("step counter left the program");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> step_r == '0)
    else $error("ready raised outside the first step");

endmodule

// File: src/fdh_datapath.sv
// ----------------------------------------------------------------------------
// fdh_datapath: store, address arithmetic and Hermite evaluator
// Driven step by step by the sequencer's control word.
// ----------------------------------------------------------------------------
module fdh_datapath import fdh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uword_t                 ctl,
  input  logic                   in_accept,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  input  logic [DELAY_W-1:0]     in_delay,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_W-1:0]       out_sample,
  output logic                   out_busy
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [WORK_W-1:0] SMAX =
    WORK_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [WORK_W-1:0] SMIN = -SMAX - WORK_W'(1);

  // control state
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              full_r, full_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [DELAY_W-1:0]             d_r;
  logic [ADDR_W-1:0]              i_r;
  logic [FRAC_BITS-1:0]           f_r;
  logic                           rd_ok_r;
  logic signed [SAMPLE_BITS-1:0]  xm1_r, x0_r, x1_r, x2_r;
  logic signed [WORK_W-1:0]       c_r, v_r, b_r, acc_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic [OUT_W-1:0]               out_sample_r;

  logic                           adv;
  logic [ADDR_W-1:0]              im1, ip1, ip2, rd_addr;
  logic [SAMPLE_BITS-1:0]         rd_data;
  logic signed [SAMPLE_BITS-1:0]  ld_val;
  logic [CMP_W-1:0]               dcmp, dsat, wpos, pos;
  logic [CMP_W:0]                 pos_raw;
  logic signed [FRAC_BITS:0]      fs;
  logic signed [PROD_W-1:0]       rsum, rshift;
  logic signed [WORK_W-1:0]       rval, dx, rhalf;
  logic [SAMPLE_BITS-1:0]         rsat;

  assign out_busy = out_valid_r && !out_tready;
  assign adv      = (ctl.op == OP_OUT) && !out_busy;

  // neighbour addresses
  assign im1 = (i_r == '0) ? LAST_ADDR : i_r - ADDR_W'(1);
  assign ip1 = next_idx(i_r);
  assign ip2 = next_idx(ip1);

  always_comb begin
    case (ctl.nb)
      NB_M1:   rd_addr = im1;
      NB_P0:   rd_addr = i_r;
      NB_P1:   rd_addr = ip1;
      NB_P2:   rd_addr = ip2;
      default: rd_addr = i_r;
    endcase
  end

  fdh_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (wp_r),
    .wr_data (SAMPLE_BITS'(in_sample)),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entries past the fill point read as zero until the first wrap
  assign ld_val = rd_ok_r ? signed'(rd_data) : '0;

  // read position: write pointer minus clamped delay, modulo the span
  always_comb begin
    dcmp = CMP_W'(d_r);
    if (dcmp < DELAY_MIN) begin
      dsat = DELAY_MIN;
    end else if (dcmp > DELAY_MAX) begin
      dsat = DELAY_MAX;
    end else begin
      dsat = dcmp;
    end
    wpos    = CMP_W'({wp_r, {FRAC_BITS{1'b0}}});
    pos_raw = {1'b0, wpos} - {1'b0, dsat};
    pos     = pos_raw[CMP_W] ? pos_raw[CMP_W-1:0] + SPAN : pos_raw[CMP_W-1:0];
  end

  // shared multiply-round path
  assign fs     = signed'({1'b0, f_r});
  assign rsum   = prod_r + RND_HALF;
  assign rshift = rsum >>> FRAC_BITS;
  assign rval   = WORK_W'(rshift);
  assign dx     = WORK_W'(x2_r) - WORK_W'(x0_r);

  // final half-LSB rounding and clamp
  always_comb begin
    rhalf = (acc_r + WORK_W'(1)) >>> 1;
    if (rhalf > SMAX) begin
      rsat = SAMPLE_BITS'(SMAX);
    end else if (rhalf < SMIN) begin
      rsat = SAMPLE_BITS'(SMIN);
    end else begin
      rsat = SAMPLE_BITS'(rhalf);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      d_r <= in_delay;
    end
    if (ctl.op == OP_ADDR) begin
      i_r <= pos[POS_W-1:FRAC_BITS];
      f_r <= pos[FRAC_BITS-1:0];
    end
    if (ctl.rd_en) begin
      rd_ok_r <= full_r || (rd_addr <= wp_r);
    end
    case (ctl.ld)
      LD_XM1:  xm1_r <= ld_val;
      LD_X0:   x0_r  <= ld_val;
      LD_X1:   x1_r  <= ld_val;
      LD_X2:   x2_r  <= ld_val;
      default: ;
    endcase
    case (ctl.op)
      OP_DIFF: begin
        c_r <= WORK_W'(x1_r) - WORK_W'(xm1_r);
        v_r <= (WORK_W'(x0_r) - WORK_W'(x1_r)) <<< 1;
      end
      OP_AB: begin
        acc_r <= c_r + (v_r <<< 1) + dx;
        b_r   <= (c_r <<< 1) + v_r + (v_r <<< 1) + dx;
      end
      OP_MUL:  prod_r <= PROD_W'(acc_r) * PROD_W'(fs);
      OP_S1:   acc_r  <= rval - b_r;
      OP_S2:   acc_r  <= rval + c_r;
      OP_S3:   acc_r  <= rval + (WORK_W'(x0_r) <<< 1);
      OP_OUT:  if (adv) begin out_sample_r <= OUT_W'(rsat); end
      default: ;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (adv) begin
      wp_nxt        = next_idx(wp_r);
      out_valid_nxt = 1'b1;
      if (wp_r == LAST_ADDR) begin
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_sample = out_sample_r;

  a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("finished result not presented");

  a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (f_r == '0) |=> out_sample_r == OUT_W'($unsigned(x0_r)))
    else $error("zero fraction must pass the center tap through");

  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(wp_r))
    else $error("write pointer moved without a result");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for fractional_delay_hermite_top
// Streams samples with fractional delays into the delay line and checks
// every interpolated output against a bit-exact Hermite predictor kept here.
// Covers field extremes, delay clamping, zero and tie fractions, overshoot
// saturation, neighbour index wrap and four handshake idle mixes.
// ----------------------------------------------------------------------------
module tb import fdh_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IN_SAMPLE_W-1:0] SMP_MAX = 24'h7FFFFF;
  localparam logic [IN_SAMPLE_W-1:0] SMP_MIN = 24'h800000;
  localparam logic [DELAY_W-1:0]     DLY_TOP = 23'h7FFFFF;
  localparam int                     DRAIN_CYCLES = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // sample_in[23:0], delay_amount[46:24]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // sample_out[23:0]

  fractional_delay_hermite_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] model_line [STORE_DEPTH];
  int                            model_wr_ptr;
  logic [OUT_W-1:0]              expected_out [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int outputs_checked = 0;
  int mismatches     = 0;

  function automatic longint frac_round(input longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Write the sample, read four neighbours at the delayed position, interpolate.
  function automatic logic [OUT_W-1:0] hermite_delay_predict(
    input logic [IN_SAMPLE_W-1:0] smp,
    input logic [DELAY_W-1:0]     dly
  );
    longint one_frac, span, d, pos, fr;
    longint xm1, x0, x1, x2, c, v, w, a, b, s1, s2, s3, r, smax, smin;
    int     idx, im1, ip1, ip2;
    one_frac = 64'sd1 <<< FRAC_BITS;
    span     = longint'(STORE_DEPTH) * one_frac;
    model_line[model_wr_ptr] = smp;
    d = longint'(dly);
    if (d < 2 * one_frac) d = 2 * one_frac;
    if (d > longint'(STORE_DEPTH - 3) * one_frac) d = longint'(STORE_DEPTH - 3) * one_frac;
    pos = longint'(model_wr_ptr) * one_frac + span - d;
    if (pos >= span) pos -= span;
    idx = int'(pos >>> FRAC_BITS);
    fr  = pos & (one_frac - 1);
    im1 = (idx == 0) ? STORE_DEPTH - 1 : idx - 1;
    ip1 = (idx + 1) % STORE_DEPTH;
    ip2 = (idx + 2) % STORE_DEPTH;
    xm1 = model_line[im1];
    x0  = model_line[idx];
    x1  = model_line[ip1];
    x2  = model_line[ip2];
    // half-LSB units keep the 0.5 factors exact
    c  = x1 - xm1;
    v  = 2 * (x0 - x1);
    w  = c + v;
    a  = w + v + (x2 - x0);
    b  = w + a;
    s1 = frac_round(a * fr) - b;
    s2 = frac_round(s1 * fr) + c;
    s3 = frac_round(s2 * fr) + 2 * x0;
    r  = (s3 + 1) >>> 1;
    smax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    smin = -smax - 1;
    if (r > smax) r = smax;
    if (r < smin) r = smin;
    model_wr_ptr = (model_wr_ptr + 1) % STORE_DEPTH;
    return r[OUT_W-1:0];
  endfunction

  function automatic logic [IN_SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return IN_SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return IN_SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(7))
      0: return DELAY_W'($urandom_range(0, 511));
      1: return DELAY_W'($urandom_range(8387840, 8388607));
      2: return DELAY_W'($urandom_range(512, 2303));
      3: return DELAY_W'($urandom_range(2, 40) << FRAC_BITS);
      default: return DELAY_W'($urandom);
    endcase
  endfunction

  // Drive one request, hold until accepted, then log its expected output.
  task automatic send_sample(input logic [IN_SAMPLE_W-1:0] smp, input logic [DELAY_W-1:0] dly);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, dly, smp};
    do @(posedge clk); while (!in_tready);
    expected_out.push_back(hermite_delay_predict(smp, dly));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(SMP_MAX, '0);                        // below minimum delay, empty store
    send_sample(SMP_MIN, DLY_TOP);                   // above maximum delay
    send_sample('0, DELAY_W'(2 << FRAC_BITS));       // exact minimum
    send_sample('1, DELAY_W'((STORE_DEPTH - 3) << FRAC_BITS)); // exact maximum
    send_sample(24'h123456, DELAY_W'(3 << FRAC_BITS));   // zero fraction
    send_sample(24'hCBA988, DELAY_W'(2 * 256 + 128));    // rounding tie
    send_sample(SMP_MAX, DELAY_W'(2 * 256 + 255));
    send_sample(SMP_MIN, DELAY_W'(513));
    // min, max, max, min then read midway between the two maxima: positive overshoot
    send_sample(SMP_MIN, DELAY_W'(600));
    send_sample(SMP_MAX, DELAY_W'(600));
    send_sample(SMP_MAX, DELAY_W'(600));
    send_sample(SMP_MIN, DELAY_W'(600));
    send_sample('0, DELAY_W'(640));
    // mirror image: negative overshoot
    send_sample(SMP_MAX, DELAY_W'(600));
    send_sample(SMP_MIN, DELAY_W'(600));
    send_sample(SMP_MIN, DELAY_W'(600));
    send_sample(SMP_MAX, DELAY_W'(600));
    send_sample('0, DELAY_W'(640));
    send_sample(24'hAAAAAA, 23'h2AAAAA);
    send_sample(24'h555555, 23'h555555);
    send_sample(24'h000001, DELAY_W'(700));
    send_sample(SMP_MAX, DELAY_W'(4 * 256 + 64));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{87, 0}, '{0, 87}, '{13, 13}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      for (int k = 0; k < 132; k++) send_sample(pick_sample(), pick_delay());
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected output sample_out=%h", $realtime, out_tdata[OUT_W-1:0]);
      end else begin
        want = expected_out.pop_front();
        outputs_checked++;
        if (out_tdata[OUT_W-1:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] output %0d: sample_out expected %h got %h", $realtime,
                     outputs_checked, want, out_tdata[OUT_W-1:0]);
        end
      end
    end
  end

  initial begin
    model_line   = '{default: '0};
    model_wr_ptr = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic();
    $display("Sent %0d samples (directed corners, four idle mixes); checked %0d outputs.",
             items_sent, outputs_checked);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("fractional_delay_hermite_top: match");
    end else begin
      $display("%0d mismatches, %0d outputs missing", mismatches, expected_out.size());
      $display("fractional_delay_hermite_top: mismatch");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timed out with %0d outputs outstanding", expected_out.size());
    $display("fractional_delay_hermite_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
src/fdh_pkg.sv
src/fdh_ram.sv
src/fdh_seq.sv
src/fdh_datapath.sv
src/fractional_delay_hermite_top.sv
sim/tb.sv
